// File: sv/text_console_terminal_defines.svh
// Assertion macros for the text console terminal.
`ifndef TEXT_CONSOLE_TERMINAL_DEFINES_SVH
`define TEXT_CONSOLE_TERMINAL_DEFINES_SVH

`ifndef SYNTH
// Checked property, quiet while reset is high.
`define TCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked property, live during reset too.
`define TCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCT_ASSERT(lbl, clk, rst, prop, msg)
`define TCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/tct_pkg.sv
// Shared types and constants of the text console terminal.
package tct_pkg;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   localparam logic [15:0] RESET_CELL   = 16'h0F20;
   localparam logic [7:0]  BLANK_CHAR   = 8'h20;
   localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

   localparam logic [1:0]  CSR_FOREGROUND = 2'd0;
   localparam logic [1:0]  CSR_BACKGROUND = 2'd1;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // latch request, clear sweep pointer and scroll flag
      logic home;       // cursor to top left
      logic put;        // write character at cursor unless newline, advance cursor
      logic rd_src;     // read cell one row below sweep pointer
      logic wr_copy;    // write read data at sweep pointer, step pointer
      logic wr_fill;    // write fill cell at sweep pointer, step pointer
      logic init_fill;  // fill uses the power-on cell
      logic rd_cell;    // read the requested cell
      logic respond;    // result beat on the outputs
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scroll_due; // current put leaves the last row
      logic copy_last;  // pointer on the last cell of the copy region
      logic fill_last;  // pointer on the last cell of the screen
   } dp_stat_type;

endpackage

// File: sv/text_console_terminal.sv
// Top level of the text console terminal: controller, datapath and checks.
//
//   channel   ports                                handshake
//   request   start, busy, req_*                   beat taken when start && !busy
//   result    rsp_strobe, rsp_*                    one-cycle beat, no back-pressure
//   config    csr_we, csr_index, csr_wdata         write on any edge with csr_we
//
// Put and read pass through a work state (ST_PUT or ST_READ), then the result state
// ST_DONE, during which the next request beat can already be taken. The unused opcode
// goes straight to ST_DONE: its result cycle follows the accepting edge directly.
// A put that scrolls copies each cell of the lower rows up a row: one memory port each
// way, so each copied cell is read in ST_SCROLL_RD and written in ST_SCROLL_WR.
// ST_BLANK then fills the last row. Clear fills the screen, one cell written per cycle.
// After reset the screen is filled with the power-on cell with busy high;
// config writes still land.
// The result side cannot stall; each result is shown for exactly one cycle.
module text_console_terminal #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_cell_row,
   input  logic [6:0]  req_cell_col,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_read_entry,
   output logic        rsp_scrolled,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

`include "text_console_terminal_defines.svh"

   tct_pkg::dp_cmd_type  cmd;
   tct_pkg::dp_stat_type stat;

   // Sequencing: which cells move in which cycle.
   tct_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Storage and arithmetic: screen memory, cursor, colours.
   tct_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_read_entry (rsp_read_entry),
      .rsp_scrolled   (rsp_scrolled)
   );

   // A taken beat either starts work or is answered in the very next cycle.
   `TCT_ASSERT(a_accept_progress, clock, reset, (start && !busy) |=> (busy || rsp_strobe), "accepted beat neither worked on nor answered")

   // A scroll always leaves the cursor on the bottom row.
   `TCT_ASSERT(a_scroll_row, clock, reset, rsp_scrolled |-> (rsp_strobe && rsp_cursor_row == 5'(ROWS - 1)), "scroll result off the bottom row")

   // Cursor column stays on screen in every result.
   `TCT_ASSERT(a_cursor_range, clock, reset, rsp_strobe |-> (32'(rsp_cursor_col) < COLUMNS), "cursor column off screen")

   // Power-on fill keeps the request side closed.
   `TCT_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> busy, "request taken during power-on fill")

endmodule

// File: sv/tct_datapath.sv
// Screen memory, cursor, colour registers and sweep pointer.
module tct_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  tct_pkg::dp_cmd_type cmd,
   output tct_pkg::dp_stat_type stat,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_char_code,
   input  logic [4:0]          req_cell_row,
   input  logic [6:0]          req_cell_col,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [3:0]          csr_wdata,
   output logic [6:0]          rsp_cursor_col,
   output logic [4:0]          rsp_cursor_row,
   output logic [15:0]         rsp_read_entry,
   output logic                rsp_scrolled
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   logic [15:0]    mem [CELL_COUNT];

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [3:0]     fg_ff, fg_in;
   logic [3:0]     bg_ff, bg_in;
   logic           scrolled_ff, scrolled_in;
   tct_pkg::op_type op_ff;
   logic [7:0]     char_ff;
   logic [AW-1:0]  cell_addr_ff;
   logic           in_range_ff;
   logic [15:0]    rd_data_ff;

   logic           req_in_range;
   logic           is_nl, col_last, row_last, wrap;
   logic [AW-1:0]  cursor_addr;
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata, fill_cell;

   // Put decode.
   assign is_nl       = (char_ff == tct_pkg::NEWLINE_CHAR);
   assign col_last    = (col_ff == CW'(COLUMNS - 1));
   assign row_last    = (row_ff == RW'(ROWS - 1));
   assign wrap        = is_nl || col_last;
   assign cursor_addr = AW'(row_ff * COLUMNS + col_ff);
   assign fill_cell   = cmd.init_fill ? tct_pkg::RESET_CELL
                                      : {bg_ff, fg_ff, tct_pkg::BLANK_CHAR};

   assign req_in_range = (32'(req_cell_row) < ROWS) && (32'(req_cell_col) < COLUMNS);

   assign stat.scroll_due = wrap && row_last;
   assign stat.copy_last  = (ptr_ff == AW'(CELL_COUNT - COLUMNS - 1));
   assign stat.fill_last  = (ptr_ff == AW'(CELL_COUNT - 1));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      ptr_in      = ptr_ff;
      scrolled_in = scrolled_ff;
      fg_in       = fg_ff;
      bg_in       = bg_ff;
      if (cmd.load) begin
         ptr_in      = '0;
         scrolled_in = 1'b0;
      end
      if (cmd.home) begin
         col_in = '0;
         row_in = '0;
      end
      if (cmd.put) begin
         col_in = wrap ? '0 : col_ff + 1'b1;
         if (wrap && !row_last) begin
            row_in = row_ff + 1'b1;
         end
         if (wrap && row_last) begin
            scrolled_in = 1'b1;
         end
      end
      if (cmd.wr_copy || cmd.wr_fill) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (csr_we) begin
         case (csr_index)
            tct_pkg::CSR_FOREGROUND: fg_in = csr_wdata;
            tct_pkg::CSR_BACKGROUND: bg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         ptr_ff      <= '0;
         scrolled_ff <= 1'b0;
         fg_ff       <= 4'hF;
         bg_ff       <= 4'h0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         ptr_ff      <= ptr_in;
         scrolled_ff <= scrolled_in;
         fg_ff       <= fg_in;
         bg_ff       <= bg_in;
      end
   end

   // Request latch, no reset.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= tct_pkg::op_type'(req_opcode);
         char_ff      <= req_char_code;
         in_range_ff  <= req_in_range;
         cell_addr_ff <= req_in_range ? AW'(req_cell_row * COLUMNS + req_cell_col) : '0;
      end
   end

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = fill_cell;
      if (cmd.put) begin
         mem_we    = !is_nl;
         mem_waddr = cursor_addr;
         mem_wdata = {bg_ff, fg_ff, char_ff};
      end else if (cmd.wr_copy) begin
         mem_we    = 1'b1;
         mem_wdata = rd_data_ff;
      end else if (cmd.wr_fill) begin
         mem_we    = 1'b1;
      end
      mem_re    = cmd.rd_src || cmd.rd_cell;
      mem_raddr = cmd.rd_cell ? cell_addr_ff : AW'(ptr_ff + COLUMNS);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_cursor_col = 7'(col_ff);
   assign rsp_cursor_row = 5'(row_ff);
   assign rsp_read_entry = (cmd.respond && op_ff == tct_pkg::OP_READ && in_range_ff)
                           ? rd_data_ff : 16'h0000;
   assign rsp_scrolled   = cmd.respond && scrolled_ff;

endmodule

// File: sv/tct_controller.sv
// Sequencer for put, scroll, clear, read and the power-on fill.
module tct_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_opcode,
   input  tct_pkg::dp_stat_type stat,
   output tct_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   tct_pkg::state_type state_ff, state_in;
   tct_pkg::state_type dispatch;
   logic               accept;

   assign busy   = !(state_ff == tct_pkg::ST_IDLE || state_ff == tct_pkg::ST_DONE);
   assign accept = start && !busy;

   always_comb begin
      unique case (tct_pkg::op_type'(req_opcode))
         tct_pkg::OP_PUT:   dispatch = tct_pkg::ST_PUT;
         tct_pkg::OP_CLEAR: dispatch = tct_pkg::ST_CLEAR;
         tct_pkg::OP_READ:  dispatch = tct_pkg::ST_READ;
         default:           dispatch = tct_pkg::ST_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tct_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tct_pkg::ST_INIT:      if (stat.fill_last) state_in = tct_pkg::ST_IDLE;
         tct_pkg::ST_IDLE:      if (accept) state_in = dispatch;
         tct_pkg::ST_PUT:       state_in = stat.scroll_due ? tct_pkg::ST_SCROLL_RD
                                                           : tct_pkg::ST_DONE;
         tct_pkg::ST_SCROLL_RD: state_in = tct_pkg::ST_SCROLL_WR;
         tct_pkg::ST_SCROLL_WR: state_in = stat.copy_last ? tct_pkg::ST_BLANK
                                                          : tct_pkg::ST_SCROLL_RD;
         tct_pkg::ST_BLANK:     if (stat.fill_last) state_in = tct_pkg::ST_DONE;
         tct_pkg::ST_CLEAR:     if (stat.fill_last) state_in = tct_pkg::ST_DONE;
         tct_pkg::ST_READ:      state_in = tct_pkg::ST_DONE;
         tct_pkg::ST_DONE:      state_in = accept ? dispatch : tct_pkg::ST_IDLE;
         default:               state_in = tct_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      rsp_strobe = 1'b0;
      cmd.load   = accept;
      cmd.home   = accept && (tct_pkg::op_type'(req_opcode) == tct_pkg::OP_CLEAR);
      unique case (state_ff)
         tct_pkg::ST_INIT: begin
            cmd.wr_fill   = 1'b1;
            cmd.init_fill = 1'b1;
         end
         tct_pkg::ST_PUT:       cmd.put     = 1'b1;
         tct_pkg::ST_SCROLL_RD: cmd.rd_src  = 1'b1;
         tct_pkg::ST_SCROLL_WR: cmd.wr_copy = 1'b1;
         tct_pkg::ST_BLANK:     cmd.wr_fill = 1'b1;
         tct_pkg::ST_CLEAR:     cmd.wr_fill = 1'b1;
         tct_pkg::ST_READ:      cmd.rd_cell = 1'b1;
         tct_pkg::ST_DONE: begin
            cmd.respond = 1'b1;
            rsp_strobe  = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// File: tb/sv/text_console_terminal_tb.sv
// Self-checking testbench for the text console terminal: directed and random traffic.
module text_console_terminal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   // Scrolls are slow, so the random part caps them
   localparam int SCROLL_CAP  = 100;
   localparam int RANDOM_BEATS = 1250;
   localparam int BURST_BEATS  = 50;
   // Slowest quiet stretch is a scroll; allow a wide margin
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 20;
   // Register indexes with no register behind them
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [15:0] entry;
      logic        scrolled;
   } console_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = tct_pkg::OP_NONE;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_cell_row = '0;
   logic [6:0]  req_cell_col = '0;
   logic        rsp_strobe;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic [15:0] rsp_read_entry;
   logic        rsp_scrolled;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_wdata = '0;

   text_console_terminal #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .rsp_strobe    (rsp_strobe),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_read_entry(rsp_read_entry),
      .rsp_scrolled  (rsp_scrolled),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the console: screen image, cursor and colour registers
   logic [15:0]        screen_image [CELL_COUNT];
   int                 shadow_col;
   int                 shadow_row;
   logic [3:0]         fg_colour;
   logic [3:0]         bg_colour;
   int                 scroll_total;
   console_report_type pending_reports [$];
   int                 mismatch_total;
   int                 stall_cycles;
   bit                 gapless;

   // Apply one command to the shadow console and return what the block should report
   function automatic console_report_type advance_console(tct_pkg::op_type op,
                                                          logic [7:0] ch,
                                                          logic [4:0] row,
                                                          logic [6:0] col);
      console_report_type rep;
      logic [15:0]        blank;
      rep   = '0;
      blank = {bg_colour, fg_colour, tct_pkg::BLANK_CHAR};
      case (op)
         tct_pkg::OP_PUT: begin
            if (ch == tct_pkg::NEWLINE_CHAR) begin
               shadow_col = 0;
               shadow_row++;
            end else begin
               screen_image[shadow_row * COLUMNS + shadow_col] = {bg_colour, fg_colour, ch};
               shadow_col++;
            end
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            // off the bottom: everything moves up a line, fresh blank line below
            if (shadow_row >= ROWS) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                  screen_image[i] = screen_image[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen_image[i] = blank;
               shadow_row   = ROWS - 1;
               rep.scrolled = 1'b1;
               scroll_total++;
            end
         end
         tct_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen_image[i] = blank;
            shadow_col = 0;
            shadow_row = 0;
         end
         tct_pkg::OP_READ: begin
            // outside the screen reads back as zero
            if (row < ROWS && col < COLUMNS)
               rep.entry = screen_image[row * COLUMNS + col];
         end
         default: ;
      endcase
      rep.col = shadow_col[6:0];
      rep.row = shadow_row[4:0];
      return rep;
   endfunction

   // Mostly back to back, now and then a short pause, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (gapless || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   // Present one beat and hold it until taken. Called just after a rising edge;
   // returns at the accepting edge with start still high.
   task automatic issue_command(tct_pkg::op_type op, logic [7:0] ch, logic [4:0] row,
                                logic [6:0] col);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_char_code <= ch;
      req_cell_row  <= row;
      req_cell_col  <= col;
      do @(posedge clock); while (busy !== 1'b0);
      pending_reports.push_back(advance_console(op, ch, row, col));
   endtask

   // Let the block run dry so the registers can be touched
   task automatic drain_console();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both colours; optionally also poke the two unused indexes
   task automatic set_colours(logic [3:0] fg, logic [3:0] bg, bit poke_spare);
      csr_we    <= 1'b1;
      csr_index <= tct_pkg::CSR_FOREGROUND;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= tct_pkg::CSR_BACKGROUND;
      csr_wdata <= bg;
      @(posedge clock);
      if (poke_spare) begin
         csr_index <= CSR_SPARE_LO;
         csr_wdata <= 4'($urandom);
         @(posedge clock);
         csr_index <= CSR_SPARE_HI;
         csr_wdata <= 4'($urandom);
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      fg_colour  = fg;
      bg_colour  = bg;
   endtask

   // Result checker: every strobe must match the oldest outstanding report
   always @(posedge clock) begin
      console_report_type want;
      console_report_type got;
      if (!reset && rsp_strobe === 1'b1) begin
         got = {rsp_cursor_col, rsp_cursor_row, rsp_read_entry, rsp_scrolled};
         if (pending_reports.size() == 0) begin
            if (mismatch_total < 10)
               $display("%0t: unexpected result beat (col %0d row %0d entry %h)",
                        $realtime, got.col, got.row, got.entry);
            mismatch_total++;
         end else begin
            want = pending_reports.pop_front();
            if (got.col !== want.col || got.row !== want.row ||
                got.entry !== want.entry || got.scrolled !== want.scrolled) begin
               if (mismatch_total < 10)
                  $display("%0t: col/row/entry/scr exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                           $realtime, want.col, want.row, want.entry, want.scrolled,
                           got.col, got.row, got.entry, got.scrolled);
               mismatch_total++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Power-on screen: corners, just outside the bottom and right edges, and the unused opcode.
   // Registers written straight out of reset while the screen is still being filled.
   task automatic test_power_on();
      set_colours(4'hF, 4'h0, 1'b1);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_READ, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
      issue_command(tct_pkg::OP_READ, 8'h00, 5'(ROWS), 7'd0);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd31, 7'd127);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd0, 7'(COLUMNS));
      issue_command(tct_pkg::OP_NONE, 8'hFF, 5'd31, 7'd127);
   endtask

   // Character extremes, newline, read-back, then clear with the new attribute
   task automatic test_put_edges();
      drain_console();
      set_colours(4'h0, 4'hF, 1'b1);
      issue_command(tct_pkg::OP_PUT, 8'h00, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, 8'h80, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, tct_pkg::NEWLINE_CHAR, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, 8'h7F, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd0, 7'd1);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
      issue_command(tct_pkg::OP_CLEAR, 8'h00, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd5, 7'd5);
   endtask

   // Newlines down to the last row; one more must scroll with current-attribute blanks
   task automatic test_scroll_on_newline();
      drain_console();
      set_colours(4'h3, 4'hC, 1'b0);
      issue_command(tct_pkg::OP_PUT, 8'h41, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, tct_pkg::NEWLINE_CHAR, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, 8'h42, 5'd0, 7'd0);
      repeat (ROWS - 2) issue_command(tct_pkg::OP_PUT, tct_pkg::NEWLINE_CHAR, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_PUT, tct_pkg::NEWLINE_CHAR, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
      issue_command(tct_pkg::OP_READ, 8'h00, 5'(ROWS - 1), 7'd5);
   endtask

   // Bursts of mixed traffic; newline density and colours change per burst
   task automatic test_random_traffic();
      logic [3:0]      extreme_fg [4] = '{4'h0, 4'hF, 4'h0, 4'hF};
      logic [3:0]      extreme_bg [4] = '{4'h0, 4'hF, 4'hF, 4'h0};
      int              nl_pct;
      int              roll;
      tct_pkg::op_type op;
      logic [7:0]      ch;
      logic [4:0]      row;
      logic [6:0]      col;
      for (int burst = 0; burst < RANDOM_BEATS / BURST_BEATS; burst++) begin
         drain_console();
         if (burst < 4)
            set_colours(extreme_fg[burst], extreme_bg[burst], 1'b0);
         else
            set_colours(4'($urandom), 4'($urandom), $urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       nl_pct = 2;
            1:       nl_pct = 12;
            default: nl_pct = 35;
         endcase
         gapless = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < BURST_BEATS; n++) begin
            roll = $urandom_range(0, 999);
            if (roll < 6)
               op = tct_pkg::OP_CLEAR;
            else if (roll < 40)
               op = tct_pkg::OP_NONE;
            else if (roll < 340)
               op = tct_pkg::OP_READ;
            else
               op = tct_pkg::OP_PUT;
            ch  = 8'($urandom);
            row = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, ROWS - 1))
                                               : 5'($urandom);
            col = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLUMNS - 1))
                                               : 7'($urandom);
            if (op == tct_pkg::OP_PUT && $urandom_range(0, 99) < nl_pct)
               ch = tct_pkg::NEWLINE_CHAR;
            // scrolls are slow; once the budget is spent, turn them into reads
            if (op == tct_pkg::OP_PUT && scroll_total >= SCROLL_CAP &&
                shadow_row == ROWS - 1 &&
                (ch == tct_pkg::NEWLINE_CHAR || shadow_col == COLUMNS - 1))
               op = tct_pkg::OP_READ;
            issue_command(op, ch, row, col);
         end
      end
      gapless = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < CELL_COUNT; i++)
         screen_image[i] = tct_pkg::RESET_CELL;
      shadow_col     = 0;
      shadow_row     = 0;
      fg_colour      = 4'hF;
      bg_colour      = 4'h0;
      scroll_total   = 0;
      mismatch_total = 0;
      stall_cycles   = 0;
      gapless        = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on();
      test_put_edges();
      test_scroll_on_newline();
      test_random_traffic();

      // everything sent; wait for the last reports, then a short tail
      drain_console();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && pending_reports.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/tct_pkg.sv
sv/tct_datapath.sv
sv/tct_controller.sv
sv/text_console_terminal.sv
tb/sv/text_console_terminal_tb.sv
